// File: hdl/point_source_dft_phasor_core_assert.svh
// Assertion macros used by the checker file of the phasor core.
`ifndef POINT_SOURCE_DFT_PHASOR_CORE_ASSERT_SVH
`define POINT_SOURCE_DFT_PHASOR_CORE_ASSERT_SVH

// General property, clocked and disabled by reset.
`define PSDFT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication.
`define PSDFT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: hdl/psdft_pkg.sv
package psdft_pkg;

   // CORDIC depth and output precision
   localparam int CORDIC_STAGES = 16;
   localparam int TRIG_BITS     = 16;
   localparam int ATAN_ENTRIES  = 30;
   localparam int ATAN_IDX_W    = $clog2(ATAN_ENTRIES);
   localparam int STAGE_W       = $clog2(CORDIC_STAGES);

   // field widths
   localparam int COORD_W       = 32;
   localparam int DIRCOS_W      = 32;
   localparam int TRIG_OUT_W    = 16;
   localparam int ANGLE_W       = 32;
   localparam int PHASE_SCALE_W = 40;
   localparam int DELTA_SCALE_W = 32;

   // datapath widths: x/y in Q2.30 with headroom, z in 2^-32 turns with sign
   localparam int XY_W = 34;
   localparam int Z_W  = 33;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 40;
   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_SCALE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DELTA_SCALE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DELTA_ENABLE = 2'd2;

   // starting gain 0.6072529350 in Q2.30
   localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;

   // pipeline depth: angle generator, fold, cells, rounding
   localparam int GEN_LAT  = 8;
   localparam int PIPE_LAT = GEN_LAT + CORDIC_STAGES + 2;

   // atan(2^-i) in 2^-32 turns
   localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   typedef struct packed {
      logic               vld;
      logic [ANGLE_W-1:0] phase_ang;
      logic [ANGLE_W-1:0] delta_ang;
   } angle_beat_type;

   typedef struct packed {
      logic                   vld;
      logic                   flip;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_beat_type;

   function automatic logic signed [Z_W-1:0] atan_step(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] res;
      res = '0;
      if (32'(idx) < ATAN_ENTRIES) begin
         res = $signed(Z_W'(ATAN_TABLE[idx]));
      end
      return res;
   endfunction

endpackage

// File: hdl/point_source_dft_phasor_core.sv
// Point-source phasor core. Give one baseline (req_u_mm, req_v_mm, req_w_mm)
// and one source direction (req_l_cos, req_m_cos, req_n_cos) with start high;
// a new beat is taken every clock cycle while busy is low (busy is high only
// right after reset). Each beat returns exactly one result, in input order:
// the multiplier pipeline forms the path difference and the phase products,
// then the angle is folded, passed through the CORDIC cells and rounded.
// The result is shown for a single cycle with rsp_valid; there is no way to
// hold it, so the receiver must take it then. Configuration registers are
// written through the csr_ port and must only change while no beat is in
// flight; rsp_delta_valid reflects delta_enable and the delta phasor reads
// zero while it is off.
module point_source_dft_phasor_core (
   input  logic                                      clock,
   input  logic                                      reset,
   // request
   input  logic                                      start,
   output logic                                      busy,
   input  logic signed [psdft_pkg::COORD_W-1:0]      req_u_mm,
   input  logic signed [psdft_pkg::COORD_W-1:0]      req_v_mm,
   input  logic signed [psdft_pkg::COORD_W-1:0]      req_w_mm,
   input  logic signed [psdft_pkg::DIRCOS_W-1:0]     req_l_cos,
   input  logic signed [psdft_pkg::DIRCOS_W-1:0]     req_m_cos,
   input  logic signed [psdft_pkg::DIRCOS_W-1:0]     req_n_cos,
   // response
   output logic                                      rsp_valid,
   output logic signed [psdft_pkg::TRIG_OUT_W-1:0]   rsp_cos_phase,
   output logic signed [psdft_pkg::TRIG_OUT_W-1:0]   rsp_sin_phase,
   output logic signed [psdft_pkg::TRIG_OUT_W-1:0]   rsp_cos_delta,
   output logic signed [psdft_pkg::TRIG_OUT_W-1:0]   rsp_sin_delta,
   output logic                                      rsp_delta_valid,
   // configuration
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [psdft_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [psdft_pkg::CSR_DATA_W-1:0]          csr_data
);

   // busy for one cycle after reset
   logic busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff;

   // configuration registers
   logic [psdft_pkg::PHASE_SCALE_W-1:0] phase_scale_ff;
   logic [psdft_pkg::DELTA_SCALE_W-1:0] delta_scale_ff;
   logic                                delta_enable_ff;
   logic                                csr_wr;

   assign csr_wr = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_scale_ff  <= '0;
         delta_scale_ff  <= '0;
         delta_enable_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_index)
            psdft_pkg::REG_PHASE_SCALE: begin
               phase_scale_ff <= csr_data[psdft_pkg::PHASE_SCALE_W-1:0];
            end
            psdft_pkg::REG_DELTA_SCALE: begin
               delta_scale_ff <= csr_data[psdft_pkg::DELTA_SCALE_W-1:0];
            end
            psdft_pkg::REG_DELTA_ENABLE: begin
               delta_enable_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // phase and delta angles
   psdft_pkg::angle_beat_type ang;
   logic                      accept;

   assign accept = start & ~busy_ff;

   psdft_phase_gen u_gen (
      .clock       (clock),
      .reset       (reset),
      .in_vld      (accept),
      .u_mm        (req_u_mm),
      .v_mm        (req_v_mm),
      .w_mm        (req_w_mm),
      .l_cos       (req_l_cos),
      .m_cos       (req_m_cos),
      .n_cos       (req_n_cos),
      .phase_scale (phase_scale_ff),
      .delta_scale (delta_scale_ff),
      .ang_out     (ang)
   );

   // two cell rows side by side
   logic                                phase_vld, delta_vld;
   logic [psdft_pkg::TRIG_OUT_W-1:0]    cos_ph, sin_ph, cos_dl, sin_dl;

   psdft_cordic_row u_row_phase (
      .clock   (clock),
      .reset   (reset),
      .ang_vld (ang.vld),
      .angle   (ang.phase_ang),
      .out_vld (phase_vld),
      .cos_out (cos_ph),
      .sin_out (sin_ph)
   );

   psdft_cordic_row u_row_delta (
      .clock   (clock),
      .reset   (reset),
      .ang_vld (ang.vld),
      .angle   (ang.delta_ang),
      .out_vld (delta_vld),
      .cos_out (cos_dl),
      .sin_out (sin_dl)
   );

   // result beat; delta phasor forced to zero when off
   assign rsp_valid       = phase_vld;
   assign rsp_cos_phase   = cos_ph;
   assign rsp_sin_phase   = sin_ph;
   assign rsp_cos_delta   = (delta_enable_ff & delta_vld) ? cos_dl : '0;
   assign rsp_sin_delta   = (delta_enable_ff & delta_vld) ? sin_dl : '0;
   assign rsp_delta_valid = delta_enable_ff;

endmodule

// File: hdl/psdft_phase_gen.sv
module psdft_phase_gen (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_vld,
   input  logic signed [psdft_pkg::COORD_W-1:0]      u_mm,
   input  logic signed [psdft_pkg::COORD_W-1:0]      v_mm,
   input  logic signed [psdft_pkg::COORD_W-1:0]      w_mm,
   input  logic signed [psdft_pkg::DIRCOS_W-1:0]     l_cos,
   input  logic signed [psdft_pkg::DIRCOS_W-1:0]     m_cos,
   input  logic signed [psdft_pkg::DIRCOS_W-1:0]     n_cos,
   input  logic [psdft_pkg::PHASE_SCALE_W-1:0]       phase_scale,
   input  logic [psdft_pkg::DELTA_SCALE_W-1:0]       delta_scale,
   output psdft_pkg::angle_beat_type                 ang_out
);

   localparam int GEN_LAT   = psdft_pkg::GEN_LAT;
   localparam int ANGLE_W   = psdft_pkg::ANGLE_W;
   localparam int MOD_W     = 100;  // bits of the products that reach any angle
   localparam int PS_SPLIT  = 20;   // phase_scale halves
   localparam int Q_CHUNK   = 25;   // slices of p for the delta product
   localparam int PHASE_LSB = 38;
   localparam int DELTA_LSB = 68;
   localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;

   // valid shift line, one bit per register level
   logic [GEN_LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[GEN_LAT-2:0], in_vld};
      end
   end

   // level 1: coordinate by direction products
   logic signed [32:0] n_minus_one;
   logic signed [63:0] ul_in, ul_ff, vm_in, vm_ff;
   logic signed [64:0] wn_in, wn_ff;

   assign n_minus_one = 33'(n_cos) - ONE_Q30;
   assign ul_in       = u_mm * l_cos;
   assign vm_in       = v_mm * m_cos;
   assign wn_in       = w_mm * n_minus_one;

   always_ff @(posedge clock) begin
      ul_ff <= ul_in;
      vm_ff <= vm_in;
      wn_ff <= wn_in;
   end

   // level 2: path difference D in 2^-30 mm
   logic signed [66:0] d_in, d_ff;

   assign d_in = 67'(ul_ff) + 67'(vm_ff) + 67'(wn_ff);

   always_ff @(posedge clock) begin
      d_ff <= d_in;
   end

   // level 3: partial products of D and phase_scale
   logic [31:0]        d0, d1;
   logic signed [2:0]  d2;
   logic [PS_SPLIT-1:0] ps0, ps1;
   logic [51:0]        pp00_in, pp01_in, pp10_in, pp11_in;
   logic [51:0]        pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic signed [23:0] pp20_in, pp21_in, pp20_ff, pp21_ff;

   assign d0  = d_ff[31:0];
   assign d1  = d_ff[63:32];
   assign d2  = d_ff[66:64];
   assign ps0 = phase_scale[PS_SPLIT-1:0];
   assign ps1 = phase_scale[2*PS_SPLIT-1:PS_SPLIT];

   assign pp00_in = 52'(d0) * 52'(ps0);
   assign pp01_in = 52'(d0) * 52'(ps1);
   assign pp10_in = 52'(d1) * 52'(ps0);
   assign pp11_in = 52'(d1) * 52'(ps1);
   assign pp20_in = 24'(d2) * 24'($signed({1'b0, ps0}));
   assign pp21_in = 24'(d2) * 24'($signed({1'b0, ps1}));

   always_ff @(posedge clock) begin
      pp00_ff <= pp00_in;
      pp01_ff <= pp01_in;
      pp10_ff <= pp10_in;
      pp11_ff <= pp11_in;
      pp20_ff <= pp20_in;
      pp21_ff <= pp21_in;
   end

   // level 4: pairwise alignment and add, modulo 2^MOD_W
   logic [MOD_W-1:0] a_in, b_in, c_in, a_ff, b_ff, c_ff;

   assign a_in = MOD_W'(pp00_ff) + (MOD_W'(pp01_ff) << PS_SPLIT);
   assign b_in = (MOD_W'(pp10_ff) << 32) + (MOD_W'(pp11_ff) << (32 + PS_SPLIT));
   assign c_in = (MOD_W'(pp20_ff) << 64) + (MOD_W'(pp21_ff) << (64 + PS_SPLIT));

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
   end

   // level 5: p = D * phase_scale
   logic [MOD_W-1:0] p_in, p_ff;

   assign p_in = a_ff + b_ff + c_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   // level 6: partial products of p and delta_scale; phase angle split off
   logic [56:0] q0_in, q1_in, q2_in, q3_in, q0_ff, q1_ff, q2_ff, q3_ff;
   logic [ANGLE_W-1:0] ph6_ff, ph7_ff;

   assign q0_in = 57'(p_ff[Q_CHUNK-1:0]) * 57'(delta_scale);
   assign q1_in = 57'(p_ff[2*Q_CHUNK-1:Q_CHUNK]) * 57'(delta_scale);
   assign q2_in = 57'(p_ff[3*Q_CHUNK-1:2*Q_CHUNK]) * 57'(delta_scale);
   assign q3_in = 57'(p_ff[4*Q_CHUNK-1:3*Q_CHUNK]) * 57'(delta_scale);

   always_ff @(posedge clock) begin
      q0_ff  <= q0_in;
      q1_ff  <= q1_in;
      q2_ff  <= q2_in;
      q3_ff  <= q3_in;
      ph6_ff <= p_ff[PHASE_LSB+ANGLE_W-1:PHASE_LSB];
   end

   // level 7: pairwise alignment and add
   logic [MOD_W-1:0] qa_in, qb_in, qa_ff, qb_ff;

   assign qa_in = MOD_W'(q0_ff) + (MOD_W'(q1_ff) << Q_CHUNK);
   assign qb_in = (MOD_W'(q2_ff) << (2 * Q_CHUNK)) + (MOD_W'(q3_ff) << (3 * Q_CHUNK));

   always_ff @(posedge clock) begin
      qa_ff  <= qa_in;
      qb_ff  <= qb_in;
      ph7_ff <= ph6_ff;
   end

   // level 8: delta product and both angles out
   logic [MOD_W-1:0]   q_sum;
   logic [ANGLE_W-1:0] delta_ang_ff, phase_ang_ff;

   assign q_sum = qa_ff + qb_ff;

   always_ff @(posedge clock) begin
      delta_ang_ff <= q_sum[DELTA_LSB+ANGLE_W-1:DELTA_LSB];
      phase_ang_ff <= ph7_ff;
   end

   assign ang_out.vld       = vld_ff[GEN_LAT-1];
   assign ang_out.phase_ang = phase_ang_ff;
   assign ang_out.delta_ang = delta_ang_ff;

endmodule

// File: hdl/psdft_cordic_cell.sv
module psdft_cordic_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [psdft_pkg::STAGE_W-1:0]    stage_idx,
   input  psdft_pkg::cordic_beat_type       beat_in,
   output psdft_pkg::cordic_beat_type       beat_out
);

   localparam int XY_W = psdft_pkg::XY_W;
   localparam int Z_W  = psdft_pkg::Z_W;

   logic signed [XY_W-1:0] x_cur, y_cur, dx, dy, x_in, y_in, x_ff, y_ff;
   logic signed [Z_W-1:0]  z_cur, step, z_in, z_ff;
   logic                   vld_ff, flip_ff;

   // one micro-rotation, direction from the sign of the residual angle
   assign x_cur = beat_in.x;
   assign y_cur = beat_in.y;
   assign z_cur = beat_in.z;
   assign dx    = y_cur >>> stage_idx;
   assign dy    = x_cur >>> stage_idx;
   assign step  = psdft_pkg::atan_step(psdft_pkg::ATAN_IDX_W'(stage_idx));

   always_comb begin
      if (z_cur[Z_W-1]) begin
         x_in = x_cur + dx;
         y_in = y_cur - dy;
         z_in = z_cur + step;
      end else begin
         x_in = x_cur - dx;
         y_in = y_cur + dy;
         z_in = z_cur - step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= beat_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      flip_ff <= beat_in.flip;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign beat_out.vld  = vld_ff;
   assign beat_out.flip = flip_ff;
   assign beat_out.x    = x_ff;
   assign beat_out.y    = y_ff;
   assign beat_out.z    = z_ff;

endmodule

// File: hdl/psdft_cordic_row.sv
module psdft_cordic_row (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  ang_vld,
   input  logic [psdft_pkg::ANGLE_W-1:0]         angle,
   output logic                                  out_vld,
   output logic [psdft_pkg::TRIG_OUT_W-1:0]      cos_out,
   output logic [psdft_pkg::TRIG_OUT_W-1:0]      sin_out
);

   localparam int XY_W       = psdft_pkg::XY_W;
   localparam int Z_W        = psdft_pkg::Z_W;
   localparam int STAGES     = psdft_pkg::CORDIC_STAGES;
   localparam int TRIG_BITS  = psdft_pkg::TRIG_BITS;
   localparam int TRIG_OUT_W = psdft_pkg::TRIG_OUT_W;
   localparam int RND_SHIFT  = 31 - TRIG_BITS;

   localparam logic signed [Z_W-1:0]  QUARTER_TURN = Z_W'(64'sd1073741824);
   localparam logic signed [Z_W-1:0]  HALF_TURN    = Z_W'(64'sd2147483648);
   localparam logic signed [XY_W:0]   RND_BIAS = (XY_W+1)'(64'sd1 <<< (RND_SHIFT - 1));
   localparam logic signed [XY_W:0]   TRIG_HI  =
      (XY_W+1)'((64'sd1 <<< (TRIG_BITS - 1)) - 64'sd1);
   localparam logic signed [XY_W:0]   TRIG_LO  = (XY_W+1)'(-(64'sd1 <<< (TRIG_BITS - 1)));

   // round half up to TRIG_BITS and saturate
   function automatic logic [TRIG_OUT_W-1:0] to_trig(input logic signed [XY_W-1:0] v);
      logic signed [XY_W:0] biased;
      logic signed [XY_W:0] q;
      biased = (XY_W+1)'(v) + RND_BIAS;
      q      = biased >>> RND_SHIFT;
      if (q > TRIG_HI) begin
         q = TRIG_HI;
      end else if (q < TRIG_LO) begin
         q = TRIG_LO;
      end
      return TRIG_OUT_W'(q);
   endfunction

   // fold the angle into a quarter turn either side of zero
   logic signed [Z_W-1:0] z_raw, z_fold_in, fold_z_ff;
   logic                  flip_in, fold_vld_ff, fold_flip_ff;

   assign z_raw = Z_W'($signed(angle));

   always_comb begin
      z_fold_in = z_raw;
      flip_in   = 1'b0;
      if (z_raw > QUARTER_TURN) begin
         z_fold_in = z_raw - HALF_TURN;
         flip_in   = 1'b1;
      end else if (z_raw < -QUARTER_TURN) begin
         z_fold_in = z_raw + HALF_TURN;
         flip_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_vld_ff <= 1'b0;
      end else begin
         fold_vld_ff <= ang_vld;
      end
   end

   always_ff @(posedge clock) begin
      fold_flip_ff <= flip_in;
      fold_z_ff    <= z_fold_in;
   end

   // row of rotation cells
   psdft_pkg::cordic_beat_type chain [STAGES+1];

   assign chain[0].vld  = fold_vld_ff;
   assign chain[0].flip = fold_flip_ff;
   assign chain[0].x    = psdft_pkg::GAIN_Q30;
   assign chain[0].y    = '0;
   assign chain[0].z    = fold_z_ff;

   for (genvar k = 0; k < STAGES; k++) begin : g_cell
      psdft_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (psdft_pkg::STAGE_W'(k)),
         .beat_in   (chain[k]),
         .beat_out  (chain[k+1])
      );
   end

   // undo the half-turn fold, then round
   logic signed [XY_W-1:0] x_end, y_end, x_fix, y_fix;
   logic                   out_vld_ff;
   logic [TRIG_OUT_W-1:0]  cos_ff, sin_ff;

   assign x_end = chain[STAGES].x;
   assign y_end = chain[STAGES].y;
   assign x_fix = chain[STAGES].flip ? -x_end : x_end;
   assign y_fix = chain[STAGES].flip ? -y_end : y_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= chain[STAGES].vld;
      end
   end

   always_ff @(posedge clock) begin
      cos_ff <= to_trig(x_fix);
      sin_ff <= to_trig(y_fix);
   end

   assign out_vld = out_vld_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// File: hdl/psdft_checker.sv
`include "point_source_dft_phasor_core_assert.svh"

module psdft_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic                                   rsp_valid,
   input logic [psdft_pkg::TRIG_OUT_W-1:0]       rsp_cos_delta,
   input logic [psdft_pkg::TRIG_OUT_W-1:0]       rsp_sin_delta,
   input logic                                   rsp_delta_valid,
   input logic                                   csr_valid,
   input logic                                   csr_ready,
   input logic [psdft_pkg::CSR_INDEX_W-1:0]      csr_index,
   input logic [psdft_pkg::CSR_DATA_W-1:0]       csr_data
);

   // every accepted beat gives a result after the fixed latency
   `PSDFT_ASSERT(a_beat_to_rsp, clock, reset, (start && !busy) |-> ##(psdft_pkg::PIPE_LAT) rsp_valid, "accepted beat produced no result")

   // no result without a beat accepted the latency earlier
   `PSDFT_ASSERT_IMP(a_rsp_from_beat, clock, reset, rsp_valid, $past(start && !busy, psdft_pkg::PIPE_LAT), "result without a matching beat")

   // delta phasor reads zero while delta is off
   `PSDFT_ASSERT_IMP(a_delta_zero, clock, reset, rsp_valid && !rsp_delta_valid, rsp_cos_delta == '0 && rsp_sin_delta == '0, "delta phasor not zero while off")

   // delta flag moves only through a write of its register
   `PSDFT_ASSERT_IMP(a_delta_flag, clock, reset, !$past(reset) && rsp_delta_valid != $past(rsp_delta_valid), $past(csr_valid && csr_ready && csr_index == psdft_pkg::REG_DELTA_ENABLE) && rsp_delta_valid == $past(csr_data[0]), "delta flag changed without a write")

endmodule

bind point_source_dft_phasor_core psdft_checker u_psdft_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_cos_delta   (rsp_cos_delta),
   .rsp_sin_delta   (rsp_sin_delta),
   .rsp_delta_valid (rsp_delta_valid),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready),
   .csr_index       (csr_index),
   .csr_data        (csr_data)
);
